// ----- rtl/char_lcd_cursor_command_gen_macros.svh -----
// assertion macros used by the lcd command generator top level
`ifndef CHAR_LCD_CURSOR_COMMAND_GEN_MACROS_SVH
`define CHAR_LCD_CURSOR_COMMAND_GEN_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CLCD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clcd assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define CLCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clcd assertion failed");

`endif

// ----- rtl/clcd_pkg.sv -----
// types, codes and helpers of the lcd cursor command generator
`timescale 1ns / 1ps
`default_nettype none
package clcd_pkg;

	localparam int COLUMNS_DEF = 20;
	localparam int ROWS_DEF    = 4;

	typedef enum logic [2:0] {
		MODE_PUT    = 3'd0,
		MODE_LINEAR = 3'd1,
		MODE_COLROW = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_HOME   = 3'd4,
		MODE_STYLE  = 3'd5
	} mode_t;

	// control characters
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// lcd command bytes
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_ENTRY   = 8'h04;
	localparam logic [7:0] CMD_DISPLAY = 8'h08;
	localparam logic [7:0] DISPLAY_ON  = 8'h04;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;
	localparam logic [7:0] CHAR_BLANK  = 8'h20;

	localparam logic [3:0][7:0] ROW_BASE = {8'h54, 8'h14, 8'h40, 8'h00};

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] char_code;
		logic [6:0] position;
		logic [4:0] column;
		logic [1:0] row;
		logic       show_cursor;
		logic       blink_cursor;
		logic       move_increment;
		logic       shift_display;
	} req_t;

	typedef struct packed {
		logic       rs;
		logic [7:0] data;
	} write_t;

	// one request's run of bus writes plus the cursor it leaves
	typedef struct packed {
		logic [1:0]       count;
		write_t [2:0]     wr;
		logic [4:0]       col;
		logic [1:0]       row;
	} run_t;

	function automatic logic [7:0] ddram_cmd(input logic [1:0] row, input logic [4:0] col);
		ddram_cmd = CMD_DDRAM | (ROW_BASE[row] + {3'b000, col});
	endfunction

endpackage
`default_nettype wire

// ----- rtl/clcd_ifs.sv -----
// request and bus write channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface clcd_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] char_code;
	logic [6:0] position;
	logic [4:0] column;
	logic [1:0] row;
	logic       show_cursor;
	logic       blink_cursor;
	logic       move_increment;
	logic       shift_display;

	modport source(output valid, mode, char_code, position, column, row, show_cursor,
		blink_cursor, move_increment, shift_display, input ready);
	modport sink(input valid, mode, char_code, position, column, row, show_cursor,
		blink_cursor, move_increment, shift_display, output ready);
endinterface

interface clcd_wr_if;
	logic       valid;
	logic       ready;
	logic       reg_select;
	logic [7:0] bus_byte;
	logic [4:0] cursor_col;
	logic [1:0] cursor_row;
	logic       last;

	modport source(output valid, reg_select, bus_byte, cursor_col, cursor_row, last,
		input ready);
	modport sink(input valid, reg_select, bus_byte, cursor_col, cursor_row, last,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/char_lcd_cursor_command_gen.sv -----
// top level of the character lcd cursor tracking command generator
// Turns cursor requests for a COLUMNS x ROWS character lcd (20x4 by default,
// row bases 0x00, 0x40, 0x14, 0x54) into runs of one to three bus writes, each
// a register select bit and a byte, while tracking the cursor column and row.
// A request lands in an input register, is decoded combinationally into a run
// register, and the run is played out on the bus channel one write per clock
// while the bus is ready. Every write carries the cursor as it stands after the
// request, and last marks the final write of the run. The bus channel is the
// bottleneck: a request holds it for each of its writes (1 to 3, none for mode
// codes 6 and 7), so the sustained rate is one bus write per clock while the
// bus is ready. The next request is taken into the input register while a run
// is still being played out, and its run loads in the same cycle the previous
// run's last write is taken, so runs follow each other with no gap. A request
// passes the input register and then the run register before its first write.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_cursor_command_gen #(
	parameter int COLUMNS = clcd_pkg::COLUMNS_DEF,
	parameter int ROWS    = clcd_pkg::ROWS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	clcd_req_if.sink    req,
	clcd_wr_if.source   bus
);
	`include "char_lcd_cursor_command_gen_macros.svh"

	localparam logic [4:0] LAST_COL = 5'(COLUMNS - 1);

	// input register
	logic             s1_valid_q;
	clcd_pkg::req_t   req_s1;

	// tracked cursor
	logic [4:0]       cur_col_q;
	logic [1:0]       cur_row_q;

	// run register and write pointer
	logic             run_valid_q;
	clcd_pkg::run_t   run_q;
	logic [1:0]       idx_q;

	clcd_pkg::run_t   dec_run;
	logic             out_take;
	logic             run_last;
	logic             run_free;
	logic             s1_take;

	clcd_decode #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_decode (
		.req    (req_s1),
		.cur_col(cur_col_q),
		.cur_row(cur_row_q),
		.run    (dec_run)
	);

	assign out_take  = bus.valid && bus.ready;
	assign run_last  = (idx_q == 2'(run_q.count - 2'd1));
	// run register frees when empty or when its last write is taken
	assign run_free  = !run_valid_q || (out_take && run_last);
	assign s1_take   = s1_valid_q && run_free;
	assign req.ready = !s1_valid_q || s1_take;

	// input register: capture a request whenever it has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= '{req.mode, req.char_code, req.position, req.column, req.row,
				req.show_cursor, req.blink_cursor, req.move_increment,
				req.shift_display};
		end
	end

	// cursor moves when the decoded request enters the run register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 5'd0;
			cur_row_q <= 2'd0;
		end else if (s1_take) begin
			cur_col_q <= dec_run.col;
			cur_row_q <= dec_run.row;
		end
	end

	// run register: load on take, step the pointer per write, drop after last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (s1_take) begin
			run_valid_q <= (dec_run.count != 2'd0);
			idx_q       <= 2'd0;
		end else if (out_take) begin
			if (run_last) begin
				run_valid_q <= 1'b0;
			end else begin
				idx_q <= 2'(idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			run_q <= dec_run;
		end
	end

	// bus channel
	assign bus.valid      = run_valid_q;
	assign bus.reg_select = run_q.wr[idx_q].rs;
	assign bus.bus_byte   = run_q.wr[idx_q].data;
	assign bus.cursor_col = run_q.col;
	assign bus.cursor_row = run_q.row;
	assign bus.last       = run_last;

	// write pointer stays inside the loaded run
	`CLCD_ASSERT_IMPL(a_idx_in_run, run_valid_q, (run_q.count != 2'd0) && (idx_q < run_q.count))
	// tracked column never leaves the display
	`CLCD_ASSERT_IMPL(a_col_range, 1'b1, cur_col_q <= LAST_COL)
	// a request is only taken into a full input register when it drains
	`CLCD_ASSERT_IMPL(a_s1_no_overwrite, req.valid && req.ready && s1_valid_q, s1_take)
	// cursor changes only when a request is decoded
	`CLCD_ASSERT_NEXT(a_cursor_hold, !s1_take, $stable(cur_col_q) && $stable(cur_row_q))
	// run empties after its last write when nothing new loads
	`CLCD_ASSERT_NEXT(a_run_drain, out_take && run_last && !s1_take, !run_valid_q)
endmodule
`default_nettype wire

// ----- rtl/clcd_decode.sv -----
// request decode: next cursor and the run of bus writes for one request
`timescale 1ns / 1ps
`default_nettype none
module clcd_decode #(
	parameter int COLUMNS = clcd_pkg::COLUMNS_DEF,
	parameter int ROWS    = clcd_pkg::ROWS_DEF
) (
	input  var clcd_pkg::req_t req,
	input  var logic [4:0]     cur_col,
	input  var logic [1:0]     cur_row,
	output clcd_pkg::run_t     run
);
	localparam logic [4:0] LAST_COL = 5'(COLUMNS - 1);
	localparam logic [1:0] LAST_ROW = 2'(ROWS - 1);
	localparam logic [6:0] LAST_CELL = 7'(COLUMNS * ROWS - 1);

	logic [4:0] nc;
	logic [1:0] nr;
	logic [6:0] pos;
	logic [7:0] cmd;

	always_comb begin
		nc  = cur_col;
		nr  = cur_row;
		pos = (req.position > LAST_CELL) ? LAST_CELL : req.position;
		case (clcd_pkg::mode_t'(req.mode))
			clcd_pkg::MODE_PUT: begin
				case (req.char_code)
					clcd_pkg::CH_NUL: ;
					clcd_pkg::CH_CR: nc = 5'd0;
					clcd_pkg::CH_LF: begin
						if (cur_row < LAST_ROW) nr = 2'(cur_row + 2'd1);
					end
					clcd_pkg::CH_BS: begin
						if (cur_col != 5'd0) begin
							nc = 5'(cur_col - 5'd1);
						end else if (cur_row != 2'd0) begin
							nr = 2'(cur_row - 2'd1);
							nc = LAST_COL;
						end
					end
					default: begin
						// advance with wrap, sticking at the last cell
						if (cur_col < LAST_COL) begin
							nc = 5'(cur_col + 5'd1);
						end else if (cur_row < LAST_ROW) begin
							nr = 2'(cur_row + 2'd1);
							nc = 5'd0;
						end else begin
							nc = LAST_COL;
							nr = LAST_ROW;
						end
					end
				endcase
			end
			clcd_pkg::MODE_LINEAR: begin
				nr = 2'd0;
				for (int r = 1; r < 4; r++) begin
					if (r < ROWS && pos >= 7'(r * COLUMNS)) nr = 2'(r);
				end
				nc = 5'(pos - 7'(int'(nr) * COLUMNS));
			end
			clcd_pkg::MODE_COLROW: begin
				nc = (req.column > LAST_COL) ? LAST_COL : req.column;
				nr = (req.row > LAST_ROW) ? LAST_ROW : req.row;
			end
			clcd_pkg::MODE_CLEAR, clcd_pkg::MODE_HOME: begin
				nc = 5'd0;
				nr = 2'd0;
			end
			default: ;
		endcase
	end

	always_comb begin
		cmd       = clcd_pkg::ddram_cmd(nr, nc);
		run       = '0;
		run.col   = nc;
		run.row   = nr;
		case (clcd_pkg::mode_t'(req.mode))
			clcd_pkg::MODE_PUT: begin
				case (req.char_code)
					clcd_pkg::CH_NUL, clcd_pkg::CH_CR, clcd_pkg::CH_LF: begin
						run.count = 2'd1;
						run.wr[0] = '{1'b0, cmd};
					end
					clcd_pkg::CH_BS: begin
						run.count = 2'd3;
						run.wr[0] = '{1'b0, cmd};
						run.wr[1] = '{1'b1, clcd_pkg::CHAR_BLANK};
						run.wr[2] = '{1'b0, cmd};
					end
					default: begin
						run.count = 2'd2;
						run.wr[0] = '{1'b1, req.char_code};
						run.wr[1] = '{1'b0, cmd};
					end
				endcase
			end
			clcd_pkg::MODE_LINEAR, clcd_pkg::MODE_COLROW: begin
				run.count = 2'd1;
				run.wr[0] = '{1'b0, cmd};
			end
			clcd_pkg::MODE_CLEAR: begin
				run.count = 2'd1;
				run.wr[0] = '{1'b0, clcd_pkg::CMD_CLEAR};
			end
			clcd_pkg::MODE_HOME: begin
				run.count = 2'd1;
				run.wr[0] = '{1'b0, clcd_pkg::CMD_HOME};
			end
			clcd_pkg::MODE_STYLE: begin
				run.count = 2'd2;
				run.wr[0] = '{1'b0, clcd_pkg::CMD_DISPLAY | clcd_pkg::DISPLAY_ON
					| {6'b000000, req.show_cursor, req.blink_cursor}};
				run.wr[1] = '{1'b0, clcd_pkg::CMD_ENTRY
					| {6'b000000, req.move_increment, req.shift_display}};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
